// File: hw/rtl/fenced_descriptor_ring_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fenced descriptor ring allocator
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FENCED_DESCRIPTOR_RING_ALLOCATOR_CORE_ASSERT_SVH
`define FENCED_DESCRIPTOR_RING_ALLOCATOR_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FDRA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another one at the following clock edge.
`define FDRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// A condition that implies another one at the same clock edge.
`define FDRA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fdra_pkg.sv
// ----------------------------------------------------------------------------
// Fenced descriptor ring allocator package
// Widths, result codes and the result record shared by the allocator files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdra_pkg;

  localparam int SLOT_BITS           = 16;
  localparam int FENCE_BITS          = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 32;

  localparam logic [SLOT_BITS-1:0] RING_LEN_RESET = SLOT_BITS'(4096);

  localparam logic [1:0] KIND_WAIT   = 2'd0;
  localparam logic [1:0] KIND_GRANT  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_FENCE  = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [FENCE_BITS-1:0] wait_value;
    logic [SLOT_BITS-1:0]  range_start;
    logic [SLOT_BITS-1:0]  range_count;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]  start;
    logic [SLOT_BITS-1:0]  count;
    logic [FENCE_BITS-1:0] fence;
  } entry_t;

endpackage

// File: hw/rtl/fdra_out_reg.sv
// ----------------------------------------------------------------------------
// Result output register
// Holds one result item towards the consumer and reports when it can load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdra_out_reg
  import fdra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  result_t               res,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [FENCE_BITS-1:0] out_wait_value,
  output logic [SLOT_BITS-1:0]  out_range_start,
  output logic [SLOT_BITS-1:0]  out_range_count,
  output logic                  out_last
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // The register is free when empty or when its item leaves this cycle.
  assign can_load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = res_r.kind;
  assign out_wait_value  = res_r.wait_value;
  assign out_range_start = res_r.range_start;
  assign out_range_count = res_r.range_count;
  assign out_last        = res_r.last;

endmodule

// File: hw/rtl/fenced_descriptor_ring_allocator_core.sv
// ----------------------------------------------------------------------------
// Fenced descriptor ring allocator
// Ring allocator over descriptor slots with a FIFO of fenced live ranges.
// ----------------------------------------------------------------------------
// A reject and a fence on an empty queue go straight to their result, and an allocate
// into an empty queue goes straight to its grant. Any other allocate reads the newest
// range and then the oldest, presents one wait result per reclaimed range, then its grant.
// A fence walks back over the untagged ranges, tagging each, and stops at a tagged one.
// Throughput: one item at a time; the next item is taken the cycle after the last result
// loads. Reset (synchronous, rst_n low): queue empty, ring size 4096, memory not cleared.
`timescale 1ns / 1ps

module fenced_descriptor_ring_allocator_core
  import fdra_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration: ring size register.
  input  logic                  cfg_we,
  input  logic [SLOT_BITS-1:0]  cfg_wdata,
  // Command items.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [SLOT_BITS-1:0]  in_count,
  input  logic [FENCE_BITS-1:0] in_fence_tag,
  // Result items.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [FENCE_BITS-1:0] out_wait_value,
  output logic [SLOT_BITS-1:0]  out_range_start,
  output logic [SLOT_BITS-1:0]  out_range_count,
  output logic                  out_last
);

`include "fenced_descriptor_ring_allocator_core_assert.svh"

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NREAD = 3'd1;
  localparam logic [2:0] S_HCHK  = 3'd2;
  localparam logic [2:0] S_PUSH  = 3'd3;
  localparam logic [2:0] S_FCHK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  // Control state.
  logic [2:0]            state_r, state_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  logic [SLOT_BITS-1:0]  ring_len_r;

  // Per-item working registers.
  logic [SLOT_BITS-1:0]  count_r, count_nxt;
  logic [SLOT_BITS-1:0]  start_r, start_nxt;
  logic [FENCE_BITS-1:0] fval_r, fval_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic [PTR_W-1:0]      walk_idx_r, walk_idx_nxt;
  logic [OCC_W-1:0]      walk_n_r, walk_n_nxt;

  // Entry memory ports.
  entry_t                mem [QUEUE_DEPTH];
  logic                  rd_en;
  logic [PTR_W-1:0]      rd_addr;
  entry_t                rd_data_r;
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  entry_t                wr_data;

  // Result path.
  logic                  can_load;
  logic                  res_load;
  result_t               res;

  // Arithmetic on the memory read data.
  logic [SLOT_BITS-1:0]  newest_end;
  logic [SLOT_BITS-1:0]  cand_start;
  logic [SLOT_BITS:0]    cand_end;
  logic [SLOT_BITS:0]    grant_end;
  logic                  head_overlaps;
  logic [OCC_W-1:0]      walk_n_inc;

  // Items are only taken while the sequencer is idle.
  assign in_stall = (state_r != S_IDLE);

  // The new range follows the newest one, and goes to slot 0 when it would
  // reach the end of the ring (an exact fit at the end also goes to slot 0).
  assign newest_end = rd_data_r.start + rd_data_r.count;
  assign cand_start = newest_end;
  assign cand_end   = {1'b0, cand_start} + {1'b0, count_r};

  // The oldest range is reclaimed when its start lies inside the new range.
  assign grant_end     = {1'b0, start_r} + {1'b0, count_r};
  assign head_overlaps = (rd_data_r.start >= start_r) &&
                         ({1'b0, rd_data_r.start} < grant_end);

  assign walk_n_inc = walk_n_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    occ_nxt      = occ_r;
    count_nxt    = count_r;
    start_nxt    = start_r;
    fval_nxt     = fval_r;
    kind_nxt     = kind_r;
    walk_idx_nxt = walk_idx_r;
    walk_n_nxt   = walk_n_r;
    rd_en        = 1'b0;
    rd_addr      = head_r;
    wr_en        = 1'b0;
    wr_addr      = tail_r;
    wr_data      = '{start: start_r, count: count_r, fence: '0};
    res_load     = 1'b0;
    res          = '{kind: kind_r, wait_value: '0, range_start: '0,
                     range_count: '0, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          count_nxt    = in_count;
          fval_nxt     = in_fence_tag;
          walk_idx_nxt = ptr_dec(tail_r);
          walk_n_nxt   = '0;
          start_nxt    = '0;
          if (in_cmd) begin
            kind_nxt = KIND_FENCE;
            if (occ_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = ptr_dec(tail_r);
              state_nxt = S_FCHK;
            end
          end else if (in_count > ring_len_r) begin
            kind_nxt  = KIND_REJECT;
            state_nxt = S_DONE;
          end else if (occ_r == '0) begin
            state_nxt = S_PUSH;
          end else begin
            // Fetch the newest range to find where the new one begins.
            rd_en     = 1'b1;
            rd_addr   = ptr_dec(tail_r);
            state_nxt = S_NREAD;
          end
        end
      end

      S_NREAD: begin
        start_nxt = (cand_end >= {1'b0, ring_len_r}) ? '0 : cand_start;
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = S_HCHK;
      end

      S_HCHK: begin
        // The read data holds the oldest live range whenever the queue is
        // not empty; it is refetched after every overlap reclaim.
        res.kind       = KIND_WAIT;
        res.wait_value = rd_data_r.fence;
        res.last       = 1'b0;
        if ((occ_r != '0) && head_overlaps) begin
          if (can_load) begin
            res_load = 1'b1;
            head_nxt = ptr_inc(head_r);
            occ_nxt  = occ_r - 1'b1;
            rd_en    = 1'b1;
            rd_addr  = ptr_inc(head_r);
          end
        end else if (occ_r == OCC_FULL) begin
          // Still full after the overlap reclaim: make room at the head.
          if (can_load) begin
            res_load  = 1'b1;
            head_nxt  = ptr_inc(head_r);
            occ_nxt   = occ_r - 1'b1;
            state_nxt = S_PUSH;
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end

      S_PUSH: begin
        res.kind        = KIND_GRANT;
        res.range_start = start_r;
        res.range_count = count_r;
        if (can_load) begin
          res_load  = 1'b1;
          wr_en     = 1'b1;
          wr_addr   = tail_r;
          tail_nxt  = ptr_inc(tail_r);
          occ_nxt   = occ_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_FCHK: begin
        // Walk back from the newest range and stop at the first tagged one.
        // The write and the next read always address different entries.
        if (rd_data_r.fence == '0) begin
          wr_en          = 1'b1;
          wr_addr        = walk_idx_r;
          wr_data        = rd_data_r;
          wr_data.fence  = fval_r;
          walk_n_nxt     = walk_n_inc;
          if (walk_n_inc < occ_r) begin
            rd_en        = 1'b1;
            rd_addr      = ptr_dec(walk_idx_r);
            walk_idx_nxt = ptr_dec(walk_idx_r);
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (can_load) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      occ_r      <= '0;
      ring_len_r <= RING_LEN_RESET;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      if (cfg_we) begin
        ring_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    start_r    <= start_nxt;
    fval_r     <= fval_nxt;
    kind_r     <= kind_nxt;
    walk_idx_r <= walk_idx_nxt;
    walk_n_r   <= walk_n_nxt;
  end

  // Entry memory: one write and one registered read per cycle. The read
  // data holds until the next read, so a stalled reclaim keeps its entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  fdra_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (res_load),
    .res             (res),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_wait_value  (out_wait_value),
    .out_range_start (out_range_start),
    .out_range_count (out_range_count),
    .out_last        (out_last)
  );

  `FDRA_ASSERT_ALWAYS(a_occ_bound, occ_r <= OCC_FULL, "occupancy exceeds queue depth")
  `FDRA_ASSERT_IMPL(a_empty_ptrs, occ_r == '0, head_r == tail_r,
                    "empty queue with unequal pointers")
  `FDRA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
                    "item taken while the previous one is still in work")
  `FDRA_ASSERT_IMPL(a_last_marks_end, out_valid, out_last == (out_kind != KIND_WAIT),
                    "last flag does not match the result kind")
  `FDRA_ASSERT_IMPL(a_load_when_busy, res_load, state_r != S_IDLE,
                    "result produced while idle")

endmodule
